[hdl/clsr_pkg.sv]
// Shared types, constants and arithmetic helpers of the combined LCG shuffle generator.
// No dependencies; imported by the top level, clsr_lcg and clsr_scale.

package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int WN_W        = $clog2(TABLE_DEPTH + 8);
    localparam int VAL_W       = 31;
    localparam int RNG_W       = 16;
    localparam int MUL_W       = 16;
    localparam int PROD_W      = VAL_W + MUL_W;

    localparam logic [VAL_W-1:0] MOD1 = 31'd2147483563;
    localparam logic [VAL_W-1:0] MOD2 = 31'd2147483399;
    localparam logic [VAL_W-1:0] TOP  = 31'd2147483562;
    localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
    localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

    localparam logic [7:0] FOLD1 = 8'(32'h8000_0000 - 32'(MOD1));
    localparam logic [7:0] FOLD2 = 8'(32'h8000_0000 - 32'(MOD2));

    localparam logic [31:0] SLOT_DIV = 32'd1 + 32'(TOP) / 32'(TABLE_DEPTH);

    localparam logic [VAL_W-1:0] SEED_RESET = 31'd3;
    localparam logic [WN_W-1:0]  WARM_STEPS = WN_W'(TABLE_DEPTH + 7);

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [RNG_W-1:0]  t_rng;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic load;
        logic step;
        logic both;
    } t_lcg_cmd;

    typedef struct packed {
        logic full;
        logic entry_busy;
    } t_scale_stat;

    // Reduces a product below 2^31 * 2^16 modulo a modulus of the form 2^31 - fold.
    function automatic t_val mod_fold(input t_prod p, input logic [7:0] fold, input t_val m);
        logic [23:0] hf;
        logic [31:0] t;
        logic [31:0] r;
        hf = 24'(p[PROD_W-1:VAL_W]) * 24'(fold);
        t  = 32'(hf) + 32'(p[VAL_W-1:0]);
        r  = (t >= {1'b0, m}) ? (t - {1'b0, m}) : t;
        return r[VAL_W-1:0];
    endfunction

    // Quotient of a product by the first modulus.
    function automatic t_rng index_of(input t_prod p);
        logic [23:0] hf;
        logic [31:0] t;
        logic [16:0] q;
        hf = 24'(p[PROD_W-1:VAL_W]) * 24'(FOLD1);
        t  = 32'(hf) + 32'(p[VAL_W-1:0]);
        q  = 17'(p[PROD_W-1:VAL_W]) + ((t >= {1'b0, MOD1}) ? 17'd1 : 17'd0);
        return q[RNG_W-1:0];
    endfunction

    function automatic t_addr slot_of(input t_val v);
        t_addr s;
        s = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if ({1'b0, v} >= 32'(k) * SLOT_DIV) begin
                s = ADDR_W'(k);
            end
        end
        return s;
    endfunction

    function automatic t_val norm_seed(input t_val v);
        t_val s;
        s = (v >= MOD1) ? (v - MOD1) : v;
        if (s == '0) begin
            s = 31'd1;
        end
        return s;
    endfunction

endpackage

[hdl/combined_lcg_shuffle_random.sv]
// Top level of the combined LCG generator with a shuffle table held in RAM.
// Depends on clsr_pkg, clsr_ram, clsr_lcg and clsr_scale.
//
// Usage: each input transaction on i_valid/o_stall carries a range and yields one output
// transaction on o_valid/i_stall with the raw 31-bit fraction and the index
// floor(fraction * range / 2147483563).
// The user must write the seed on i_cfg_valid/o_cfg_ready only while the block is
// idle; the block itself does not enforce this. The write forces a fresh warm-up at
// the next request. Once warmed up, a request reads the table entry at the slot of
// the last output, replaces it with a new generator value and forms the new output,
// which selects the next slot; the next request is taken after that update.
// The first request after reset or after a seed write first runs the warm-up: a
// multiply and a fold state for each of the TABLE_DEPTH + 8 generator steps, then a
// prime state that steps both generators, before the table read and update.
// Reset loads the seed 3 and clears all valid state; the table needs no clearing pass as
// the warm-up writes every entry before any read.
// When the receiver stalls, results queue in three internal stages. The input is stalled
// while a request is being processed and while all three stages are occupied.

module combined_lcg_shuffle_random import clsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_rng i_range,
    output logic o_valid,
    input  logic i_stall,
    output t_val o_fraction,
    output t_rng o_index,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  t_val i_cfg_seed
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_WARM_MUL  = 3'd1;
    localparam logic [2:0] ST_WARM_FOLD = 3'd2;
    localparam logic [2:0] ST_PRIME     = 3'd3;
    localparam logic [2:0] ST_READ      = 3'd4;
    localparam logic [2:0] ST_UPD       = 3'd5;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic        r_warm;
    logic        n_warm;
    t_val        r_seed;
    t_rng        r_range;
    t_rng        n_range;
    t_val        r_last;
    t_val        n_last;
    t_addr       r_slot;
    t_addr       n_slot;
    logic [WN_W-1:0] r_wn;
    logic [WN_W-1:0] n_wn;

    t_lcg_cmd    lcg_cmd;
    t_val        w_x1;
    t_val        w_x2;
    t_val        w_next1;
    logic        w_lcg_busy;
    t_scale_stat w_stat;

    logic        ram_wr_en;
    t_addr       ram_wr_addr;
    t_val        ram_wr_data;
    logic        ram_rd_en;
    t_val        ram_rd_data;

    logic        in_accept;
    logic        upd_load;
    t_addr       w_slot;
    t_val        w_y;

    assign o_stall     = !(r_state == ST_IDLE && !w_stat.full);
    assign in_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign w_slot      = slot_of(r_last);

    always_comb begin
        if (ram_rd_data > w_x2) begin
            w_y = ram_rd_data - w_x2;
        end else begin
            w_y = VAL_W'(32'(ram_rd_data) + 32'(TOP) - 32'(w_x2));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_warm      = r_warm;
        n_range     = r_range;
        n_last      = r_last;
        n_slot      = r_slot;
        n_wn        = r_wn;
        lcg_cmd     = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_slot;
        ram_wr_data = w_x1;
        ram_rd_en   = 1'b0;
        upd_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_range = i_range;
                    if (r_warm) begin
                        ram_rd_en = 1'b1;
                        n_slot    = w_slot;
                        n_state   = ST_UPD;
                    end else begin
                        lcg_cmd.load = 1'b1;
                        n_wn         = WARM_STEPS;
                        n_state      = ST_WARM_MUL;
                    end
                end
            end
            ST_WARM_MUL: begin
                lcg_cmd.step = 1'b1;
                n_state      = ST_WARM_FOLD;
            end
            ST_WARM_FOLD: begin
                if (r_wn < WN_W'(TABLE_DEPTH)) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_wn[ADDR_W-1:0];
                    ram_wr_data = w_next1;
                end
                if (r_wn == '0) begin
                    n_last  = w_next1;
                    n_warm  = 1'b1;
                    n_state = ST_PRIME;
                end else begin
                    n_wn    = r_wn - 1'b1;
                    n_state = ST_WARM_MUL;
                end
            end
            ST_PRIME: begin
                lcg_cmd.step = 1'b1;
                lcg_cmd.both = 1'b1;
                n_state      = ST_READ;
            end
            ST_READ: begin
                ram_rd_en = 1'b1;
                n_slot    = w_slot;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                ram_wr_en    = 1'b1;
                n_last       = w_y;
                upd_load     = 1'b1;
                lcg_cmd.step = 1'b1;
                lcg_cmd.both = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg_valid && o_cfg_ready) begin
            n_warm = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_warm  <= 1'b0;
            r_seed  <= SEED_RESET;
            r_wn    <= '0;
        end else begin
            r_state <= n_state;
            r_warm  <= n_warm;
            r_wn    <= n_wn;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
        r_last  <= n_last;
        r_slot  <= n_slot;
    end

    clsr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (w_slot),
        .o_rd_data (ram_rd_data)
    );

    clsr_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (lcg_cmd),
        .i_seed  (r_seed),
        .o_x1    (w_x1),
        .o_x2    (w_x2),
        .o_next1 (w_next1),
        .o_busy  (w_lcg_busy)
    );

    clsr_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (upd_load),
        .i_frac     (w_y),
        .i_range    (r_range),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_fraction (o_fraction),
        .o_index    (o_index)
    );

`ifndef NO_ASSERTIONS
    a_upd_lcg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> !w_lcg_busy)
        else $error("Generator update still pending when the table entry is replaced.");

    a_upd_entry_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> !w_stat.entry_busy)
        else $error("Scaling stage occupied when a new result arrives.");

    a_upd_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> r_warm)
        else $error("Table read before the warm-up completed.");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fraction != '0 && o_fraction <= TOP))
        else $error("Output fraction outside its range.");
`endif

endmodule

[hdl/clsr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.

module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/clsr_lcg.sv]
// The two multiplicative generators: a registered product, then a modular fold.
// Depends on clsr_pkg.

module clsr_lcg import clsr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_lcg_cmd i_cmd,
    input  t_val     i_seed,
    output t_val     o_x1,
    output t_val     o_x2,
    output t_val     o_next1,
    output logic     o_busy
);

    t_val  r_x1;
    t_val  r_x2;
    t_prod r_p1;
    t_prod r_p2;
    logic  r_pend;
    logic  r_both;
    t_val  n_x1;
    t_val  n_x2;

    assign n_x1 = mod_fold(r_p1, FOLD1, MOD1);
    assign n_x2 = mod_fold(r_p2, FOLD2, MOD2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_both <= 1'b0;
        end else begin
            r_pend <= i_cmd.step;
            if (i_cmd.step) begin
                r_both <= i_cmd.both;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x1 <= norm_seed(i_seed);
            r_x2 <= norm_seed(i_seed);
        end else if (r_pend) begin
            r_x1 <= n_x1;
            if (r_both) begin
                r_x2 <= n_x2;
            end
        end
        if (i_cmd.step) begin
            r_p1 <= PROD_W'(r_x1) * PROD_W'(MUL1);
            r_p2 <= PROD_W'(r_x2) * PROD_W'(MUL2);
        end
    end

    assign o_x1    = r_x1;
    assign o_x2    = r_x2;
    assign o_next1 = n_x1;
    assign o_busy  = r_pend;

endmodule

[hdl/clsr_scale.sv]
// Index scaling pipeline and output register: product, division by the modulus, result.
// Depends on clsr_pkg.

module clsr_scale import clsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_val        i_frac,
    input  t_rng        i_range,
    output t_scale_stat o_stat,
    output logic        o_valid,
    input  logic        i_stall,
    output t_val        o_fraction,
    output t_rng        o_index
);

    logic  r_pv;
    logic  r_mv;
    logic  r_ov;
    t_val  r_pv_frac;
    t_rng  r_pv_rng;
    t_val  r_mv_frac;
    t_prod r_mv_prod;
    t_val  r_o_frac;
    t_rng  r_o_idx;
    logic  o_load;
    logic  mv_load;

    assign o_load  = r_mv && (!r_ov || !i_stall);
    assign mv_load = r_pv && (!r_mv || o_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= i_load || (r_pv && !mv_load);
            r_mv <= mv_load || (r_mv && !o_load);
            r_ov <= o_load || (r_ov && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pv_frac <= i_frac;
            r_pv_rng  <= i_range;
        end
        if (mv_load) begin
            r_mv_frac <= r_pv_frac;
            r_mv_prod <= PROD_W'(r_pv_frac) * PROD_W'(r_pv_rng);
        end
        if (o_load) begin
            r_o_frac <= r_mv_frac;
            r_o_idx  <= index_of(r_mv_prod);
        end
    end

    assign o_stat.full       = r_pv && r_mv && r_ov;
    assign o_stat.entry_busy = r_pv && !mv_load;
    assign o_valid           = r_ov;
    assign o_fraction        = r_o_frac;
    assign o_index           = r_o_idx;

endmodule
